// ===== src/mflb_pkg.sv =====
// ----------------------------------------------------------------------------
// Misaligned fetch line buffer package
// Shared constants, the line lookup result type and the word selection
// functions of the fetch line buffer.
// ----------------------------------------------------------------------------
package mflb_pkg;

   localparam int ADDR_WIDTH_DEFAULT = 32;
   localparam int LINE_WIDTH = 64;
   localparam int WORD_WIDTH = 32;
   localparam int HALF_WIDTH = 16;
   localparam int OFFSET_BITS = 3;
   localparam int STATE_WIDTH = 2;

   localparam logic [2:0] SRC_NONE = 3'b000;
   localparam logic [2:0] SRC_L1 = 3'b001;
   localparam logic [2:0] SRC_L2 = 3'b010;
   localparam logic [2:0] SRC_RSP = 3'b100;

   localparam logic [1:0] SEL_LOW = 2'd0;
   localparam logic [1:0] SEL_MID = 2'd1;
   localparam logic [1:0] SEL_HIGH = 2'd2;
   localparam logic [1:0] SEL_STRADDLE = 2'd3;

   typedef struct packed {
      logic [2:0] src;
      logic [LINE_WIDTH-1:0] data;
      logic fault;
   } mflb_hit_type;

   function automatic logic [WORD_WIDTH-1:0] pick_word(
      input logic [1:0] sel,
      input logic [LINE_WIDTH-1:0] d0,
      input logic [LINE_WIDTH-1:0] d1
   );
      logic [WORD_WIDTH-1:0] word;
      unique case (sel)
         SEL_LOW: word = d0[31:0];
         SEL_MID: word = d0[47:16];
         SEL_HIGH: word = d0[63:32];
         default: word = {d1[HALF_WIDTH-1:0], d0[63:48]};
      endcase
      return word;
   endfunction

   function automatic logic pick_fault(
      input logic [1:0] sel,
      input logic f0,
      input logic f1
   );
      return (sel == SEL_STRADDLE) ? (f0 | f1) : f0;
   endfunction

endpackage

// ===== src/mflb_lookup.sv =====
// ----------------------------------------------------------------------------
// Line lookup
// Finds the stored line, or the line arriving from memory, that holds an
// address and returns its data, fault bit and source.
// ----------------------------------------------------------------------------
module mflb_lookup
   import mflb_pkg::*;
#(
   parameter int ADDR_WIDTH = ADDR_WIDTH_DEFAULT
) (
   input  logic [ADDR_WIDTH-1:0] addr,
   input  logic line_en,
   input  logic rsp_en,
   input  logic [ADDR_WIDTH-OFFSET_BITS-1:0] tag0,
   input  logic [ADDR_WIDTH-OFFSET_BITS-1:0] tag1,
   input  logic [LINE_WIDTH-1:0] data0,
   input  logic [LINE_WIDTH-1:0] data1,
   input  logic fault0,
   input  logic fault1,
   input  logic [ADDR_WIDTH-OFFSET_BITS-1:0] pend_tag,
   input  logic [LINE_WIDTH-1:0] rsp_data,
   input  logic rsp_fault,
   output mflb_hit_type hit
);

   logic [ADDR_WIDTH-OFFSET_BITS-1:0] tag;

   assign tag = addr[ADDR_WIDTH-1:OFFSET_BITS];

   always_comb begin
      hit = '0;
      priority if (tag == tag0) begin
         hit.data = data0;
         hit.fault = fault0;
         hit.src = line_en ? SRC_L1 : SRC_NONE;
      end else if (tag == tag1) begin
         hit.data = data1;
         hit.fault = fault1;
         hit.src = line_en ? SRC_L2 : SRC_NONE;
      end else if (tag == pend_tag) begin
         hit.data = rsp_data;
         hit.fault = rsp_fault;
         hit.src = rsp_en ? SRC_RSP : SRC_NONE;
      end else begin
         hit.src = SRC_NONE;
      end
   end

endmodule

// ===== src/mflb_core.sv =====
// ----------------------------------------------------------------------------
// Fetch line buffer core
// Holds the two lines, the handshake controller and the delayed-hit word,
// and advances them by one clock of port values per step.
// ----------------------------------------------------------------------------
module mflb_core
   import mflb_pkg::*;
#(
   parameter int ADDR_WIDTH = ADDR_WIDTH_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic step_en,
   input  logic in_req_valid,
   input  logic [ADDR_WIDTH-1:0] in_req_address,
   input  logic in_mem_req_ready,
   input  logic in_mem_resp_valid,
   input  logic [LINE_WIDTH-1:0] in_mem_resp_data,
   input  logic in_mem_resp_fault,
   input  logic in_resp_ready,
   input  logic in_flush,
   output logic out_req_ready,
   output logic out_mem_req_valid,
   output logic [ADDR_WIDTH-1:0] out_mem_req_address,
   output logic out_resp_valid,
   output logic [ADDR_WIDTH-1:0] out_resp_address,
   output logic [WORD_WIDTH-1:0] out_resp_data,
   output logic out_resp_fault,
   output logic [STATE_WIDTH-1:0] out_control_state
);

   localparam int TW = ADDR_WIDTH - OFFSET_BITS;

   typedef enum logic [STATE_WIDTH-1:0] {
      ST_IDLE,
      ST_GRANT,
      ST_RESP,
      ST_ACCEPT
   } state_type;

   function automatic state_type after_accept(input logic need, input logic mrdy);
      state_type nxt;
      if (!need) begin
         nxt = ST_ACCEPT;
      end else if (mrdy) begin
         nxt = ST_RESP;
      end else begin
         nxt = ST_GRANT;
      end
      return nxt;
   endfunction

   state_type state_ff, state_in;
   logic [TW-1:0] tag0_ff, tag0_in, tag1_ff, tag1_in;
   logic [LINE_WIDTH-1:0] data0_ff, data0_in, data1_ff, data1_in;
   logic fault0_ff, fault0_in, fault1_ff, fault1_in;
   logic [ADDR_WIDTH-1:0] pend_ff, pend_in;
   logic [ADDR_WIDTH-1:0] cur_ff, cur_in;
   logic dbl_ff, dbl_in;
   logic held_valid_ff, held_valid_in;
   logic [WORD_WIDTH-1:0] held_word_ff, held_word_in;
   logic held_fault_ff, held_fault_in;

   logic waitr, rcv, need, reuse, rready, memv;
   logic [ADDR_WIDTH-1:0] a0, a1, h1, maddr;
   logic [TW-1:0] ptag;
   logic [2:0] any_src, hold_src;
   mflb_hit_type hit0, hit1, hold0, hold1;

   assign waitr = (state_ff == ST_RESP) && !in_mem_resp_valid;
   assign rcv = !waitr && (in_req_valid || dbl_ff);
   assign a0 = dbl_ff ? cur_ff : in_req_address;
   assign a1 = a0 + ADDR_WIDTH'(2);
   assign h1 = cur_ff + ADDR_WIDTH'(2);
   assign ptag = pend_ff[ADDR_WIDTH-1:OFFSET_BITS];

   mflb_lookup #(.ADDR_WIDTH(ADDR_WIDTH)) u_hit0 (
      .addr(a0), .line_en(rcv), .rsp_en(in_mem_resp_valid),
      .tag0(tag0_ff), .tag1(tag1_ff), .data0(data0_ff), .data1(data1_ff),
      .fault0(fault0_ff), .fault1(fault1_ff), .pend_tag(ptag),
      .rsp_data(in_mem_resp_data), .rsp_fault(in_mem_resp_fault), .hit(hit0)
   );

   mflb_lookup #(.ADDR_WIDTH(ADDR_WIDTH)) u_hit1 (
      .addr(a1), .line_en(rcv), .rsp_en(in_mem_resp_valid),
      .tag0(tag0_ff), .tag1(tag1_ff), .data0(data0_ff), .data1(data1_ff),
      .fault0(fault0_ff), .fault1(fault1_ff), .pend_tag(ptag),
      .rsp_data(in_mem_resp_data), .rsp_fault(in_mem_resp_fault), .hit(hit1)
   );

   mflb_lookup #(.ADDR_WIDTH(ADDR_WIDTH)) u_hold0 (
      .addr(cur_ff), .line_en(1'b1), .rsp_en(1'b0),
      .tag0(tag0_ff), .tag1(tag1_ff), .data0(data0_ff), .data1(data1_ff),
      .fault0(fault0_ff), .fault1(fault1_ff), .pend_tag(ptag),
      .rsp_data(in_mem_resp_data), .rsp_fault(in_mem_resp_fault), .hit(hold0)
   );

   mflb_lookup #(.ADDR_WIDTH(ADDR_WIDTH)) u_hold1 (
      .addr(h1), .line_en(1'b1), .rsp_en(1'b0),
      .tag0(tag0_ff), .tag1(tag1_ff), .data0(data0_ff), .data1(data1_ff),
      .fault0(fault0_ff), .fault1(fault1_ff), .pend_tag(ptag),
      .rsp_data(in_mem_resp_data), .rsp_fault(in_mem_resp_fault), .hit(hold1)
   );

   assign need = !((hit0.src != SRC_NONE) && (hit1.src != SRC_NONE));
   assign memv = need && rcv;
   assign rready = !need || (in_mem_req_ready && !waitr);
   assign any_src = hit0.src | hit1.src;
   assign hold_src = hold0.src | hold1.src;

   always_comb begin
      priority if (dbl_ff) begin
         maddr = {h1[ADDR_WIDTH-1:OFFSET_BITS], OFFSET_BITS'(0)};
      end else if (hit0.src == SRC_NONE) begin
         maddr = {a0[ADDR_WIDTH-1:OFFSET_BITS], OFFSET_BITS'(0)};
      end else begin
         maddr = {a1[ADDR_WIDTH-1:OFFSET_BITS], OFFSET_BITS'(0)};
      end
   end

   always_comb begin
      if (in_resp_ready) begin
         reuse = ((any_src & SRC_L2) != SRC_NONE)
                 && (tag1_ff != maddr[ADDR_WIDTH-1:OFFSET_BITS]) && need;
      end else begin
         reuse = ((hold_src & SRC_L2) != SRC_NONE) && ((hold_src & SRC_L1) == SRC_NONE)
                 && (tag1_ff != ptag);
      end
   end

   always_comb begin
      state_in = state_ff;
      dbl_in = dbl_ff;
      cur_in = cur_ff;
      pend_in = pend_ff;
      held_valid_in = held_valid_ff;
      held_word_in = held_word_ff;
      held_fault_in = held_fault_ff;
      tag0_in = tag0_ff;
      tag1_in = tag1_ff;
      data0_in = data0_ff;
      data1_in = data1_ff;
      fault0_in = fault0_ff;
      fault1_in = fault1_ff;

      if (rcv && !need) begin
         held_valid_in = 1'b1;
         held_word_in = pick_word(in_req_address[2:1], hit0.data, hit1.data);
         held_fault_in = pick_fault(in_req_address[2:1], hit0.fault, hit1.fault);
      end else if (in_resp_ready) begin
         held_valid_in = 1'b0;
         held_word_in = '0;
         held_fault_in = 1'b0;
      end

      if ((memv && in_mem_req_ready && !waitr) || (dbl_ff && !waitr)) begin
         pend_in = maddr;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (rcv) begin
               state_in = after_accept(need, in_mem_req_ready);
            end
         end
         ST_GRANT: begin
            priority if (in_mem_req_ready) begin
               state_in = ST_RESP;
            end else if (!need) begin
               state_in = ST_ACCEPT;
            end else begin
               state_in = ST_GRANT;
            end
         end
         ST_RESP: begin
            if (in_mem_resp_valid) begin
               priority if (!in_resp_ready) begin
                  state_in = ST_ACCEPT;
               end else if (!rcv) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = after_accept(need, in_mem_req_ready);
               end
            end
         end
         default: begin
            if (in_resp_ready) begin
               state_in = rcv ? after_accept(need, in_mem_req_ready) : ST_IDLE;
            end
         end
      endcase

      if (rcv && rready) begin
         dbl_in = (in_req_address[2:1] == SEL_STRADDLE) && (hit0.src == SRC_NONE)
                  && (hit1.src == SRC_NONE) && !dbl_ff;
         if (!dbl_ff) begin
            cur_in = in_req_address;
         end
      end

      if (in_mem_resp_valid) begin
         if (!reuse) begin
            tag1_in = tag0_ff;
            data1_in = data0_ff;
            fault1_in = fault0_ff;
         end
         tag0_in = ptag;
         data0_in = in_mem_resp_data;
         fault0_in = in_mem_resp_fault;
      end
      if (in_flush) begin
         tag0_in = '1;
         tag1_in = '1;
      end
   end

   assign out_req_ready = rready;
   assign out_mem_req_valid = memv;
   assign out_mem_req_address = maddr;
   assign out_resp_valid = (state_ff == ST_ACCEPT) ? !dbl_ff : (in_mem_resp_valid && !dbl_ff);
   assign out_resp_address = cur_ff;
   assign out_resp_data = held_valid_ff ? held_word_ff
                                        : pick_word(cur_ff[2:1], hold0.data, hold1.data);
   assign out_resp_fault = held_valid_ff ? held_fault_ff
                                         : pick_fault(cur_ff[2:1], hold0.fault, hold1.fault);
   assign out_control_state = state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         tag0_ff <= '1;
         tag1_ff <= '1;
         data0_ff <= '0;
         data1_ff <= '0;
         fault0_ff <= 1'b0;
         fault1_ff <= 1'b0;
         pend_ff <= '0;
         cur_ff <= '0;
         dbl_ff <= 1'b0;
         held_valid_ff <= 1'b0;
         held_word_ff <= '0;
         held_fault_ff <= 1'b0;
      end else if (step_en) begin
         state_ff <= state_in;
         tag0_ff <= tag0_in;
         tag1_ff <= tag1_in;
         data0_ff <= data0_in;
         data1_ff <= data1_in;
         fault0_ff <= fault0_in;
         fault1_ff <= fault1_in;
         pend_ff <= pend_in;
         cur_ff <= cur_in;
         dbl_ff <= dbl_in;
         held_valid_ff <= held_valid_in;
         held_word_ff <= held_word_in;
         held_fault_ff <= held_fault_in;
      end
   end

endmodule

// ===== src/misaligned_fetch_line_buffer.sv =====
// A request passes from the input register to the result register before its result
// is on the rsp ports; it waits in the input register while the held result is stalled.
// Throughput: one request per clock while not stalled; the input register passes its
// request to the result register whenever that register is empty or is being taken.
// Reset is synchronous and active high; it empties both registers, sets both line
// tags to all ones and clears the rest of the state.
// ----------------------------------------------------------------------------
// Misaligned fetch line buffer
// Takes one clock of fetch and memory port values per request and returns that
// clock's port outputs, stepping the fetch line buffer state once per request.
// ----------------------------------------------------------------------------
module misaligned_fetch_line_buffer
   import mflb_pkg::*;
#(
   parameter int ADDR_WIDTH = ADDR_WIDTH_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic req_req_valid,
   input  logic [ADDR_WIDTH-1:0] req_req_address,
   input  logic req_mem_req_ready,
   input  logic req_mem_resp_valid,
   input  logic [LINE_WIDTH-1:0] req_mem_resp_data,
   input  logic req_mem_resp_fault,
   input  logic req_resp_ready,
   input  logic req_flush,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic rsp_req_ready,
   output logic rsp_mem_req_valid,
   output logic [ADDR_WIDTH-1:0] rsp_mem_req_address,
   output logic rsp_resp_valid,
   output logic [ADDR_WIDTH-1:0] rsp_resp_address,
   output logic [WORD_WIDTH-1:0] rsp_resp_data,
   output logic rsp_resp_fault,
   output logic [STATE_WIDTH-1:0] rsp_control_state
);

   logic in_valid_ff;
   logic in_req_valid_ff;
   logic [ADDR_WIDTH-1:0] in_req_address_ff;
   logic in_mem_req_ready_ff;
   logic in_mem_resp_valid_ff;
   logic [LINE_WIDTH-1:0] in_mem_resp_data_ff;
   logic in_mem_resp_fault_ff;
   logic in_resp_ready_ff;
   logic in_flush_ff;

   logic out_valid_ff;
   logic out_req_ready_ff;
   logic out_mem_req_valid_ff;
   logic [ADDR_WIDTH-1:0] out_mem_req_address_ff;
   logic out_resp_valid_ff;
   logic [ADDR_WIDTH-1:0] out_resp_address_ff;
   logic [WORD_WIDTH-1:0] out_resp_data_ff;
   logic out_resp_fault_ff;
   logic [STATE_WIDTH-1:0] out_control_state_ff;

   logic accept, advance;
   logic core_req_ready, core_mem_req_valid, core_resp_valid, core_resp_fault;
   logic [ADDR_WIDTH-1:0] core_mem_req_address, core_resp_address;
   logic [WORD_WIDTH-1:0] core_resp_data;
   logic [STATE_WIDTH-1:0] core_control_state;

   assign advance = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && out_valid_ff && rsp_stall;
   assign accept = req_valid && !req_stall;

   mflb_core #(.ADDR_WIDTH(ADDR_WIDTH)) u_core (
      .clock(clock),
      .reset(reset),
      .step_en(advance),
      .in_req_valid(in_req_valid_ff),
      .in_req_address(in_req_address_ff),
      .in_mem_req_ready(in_mem_req_ready_ff),
      .in_mem_resp_valid(in_mem_resp_valid_ff),
      .in_mem_resp_data(in_mem_resp_data_ff),
      .in_mem_resp_fault(in_mem_resp_fault_ff),
      .in_resp_ready(in_resp_ready_ff),
      .in_flush(in_flush_ff),
      .out_req_ready(core_req_ready),
      .out_mem_req_valid(core_mem_req_valid),
      .out_mem_req_address(core_mem_req_address),
      .out_resp_valid(core_resp_valid),
      .out_resp_address(core_resp_address),
      .out_resp_data(core_resp_data),
      .out_resp_fault(core_resp_fault),
      .out_control_state(core_control_state)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_req_valid_ff <= req_req_valid;
         in_req_address_ff <= req_req_address;
         in_mem_req_ready_ff <= req_mem_req_ready;
         in_mem_resp_valid_ff <= req_mem_resp_valid;
         in_mem_resp_data_ff <= req_mem_resp_data;
         in_mem_resp_fault_ff <= req_mem_resp_fault;
         in_resp_ready_ff <= req_resp_ready;
         in_flush_ff <= req_flush;
      end
      if (advance) begin
         out_req_ready_ff <= core_req_ready;
         out_mem_req_valid_ff <= core_mem_req_valid;
         out_mem_req_address_ff <= core_mem_req_address;
         out_resp_valid_ff <= core_resp_valid;
         out_resp_address_ff <= core_resp_address;
         out_resp_data_ff <= core_resp_data;
         out_resp_fault_ff <= core_resp_fault;
         out_control_state_ff <= core_control_state;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_req_ready = out_req_ready_ff;
   assign rsp_mem_req_valid = out_mem_req_valid_ff;
   assign rsp_mem_req_address = out_mem_req_address_ff;
   assign rsp_resp_valid = out_resp_valid_ff;
   assign rsp_resp_address = out_resp_address_ff;
   assign rsp_resp_data = out_resp_data_ff;
   assign rsp_resp_fault = out_resp_fault_ff;
   assign rsp_control_state = out_control_state_ff;

`ifndef SYNTHESIS
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && in_valid_ff))
      else $error("Input stalled while the result register can take a request.");

   a_line_address_aligned: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_mem_req_address[OFFSET_BITS-1:0] == '0))
      else $error("Line request address is not line aligned.");

   a_accept_fills_input: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> in_valid_ff)
      else $error("Accepted request did not reach the input register.");

   a_advance_fills_output: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("Stepped request did not reach the result register.");
`endif

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// Misaligned fetch line buffer testbench
// Drives one clock of fetch and memory port values per request and checks the
// returned port values against a cycle model of the two-line fetch buffer.
// Most traffic follows a fetch unit and a memory that answer the handshake,
// with the rest as random noise. Both channels idle at varying rates.
// ----------------------------------------------------------------------------
module tb
   import mflb_pkg::*;
();

   localparam int AW = ADDR_WIDTH_DEFAULT;
   localparam int TW = AW - OFFSET_BITS;
   localparam int STALL_LIMIT = 5000;
   localparam int ITEMS_PER_PHASE = 534;

   typedef enum logic [1:0] {HS_IDLE, HS_GRANT, HS_RESP, HS_ACCEPT} hs_state_type;

   typedef struct packed {
      logic req_valid;
      logic [AW-1:0] req_address;
      logic mem_req_ready;
      logic mem_resp_valid;
      logic [LINE_WIDTH-1:0] mem_resp_data;
      logic mem_resp_fault;
      logic resp_ready;
      logic flush;
   } fetch_cycle_type;

   typedef struct packed {
      logic req_ready;
      logic mem_req_valid;
      logic [AW-1:0] mem_req_address;
      logic resp_valid;
      logic [AW-1:0] resp_address;
      logic [WORD_WIDTH-1:0] resp_data;
      logic resp_fault;
      logic [STATE_WIDTH-1:0] control_state;
   } port_outputs_type;

   class line_buffer_scoreboard;
      logic [TW-1:0] tag[2];
      logic [LINE_WIDTH-1:0] line[2];
      logic line_flt[2];
      logic [AW-1:0] pend_addr;
      logic [AW-1:0] cur_addr;
      logic second_half;
      logic held_valid;
      logic [WORD_WIDTH-1:0] held_word;
      logic held_fault;
      hs_state_type hs_state;
      port_outputs_type expected_outputs[$];
      int errors;
      int requests;
      int checked;
      int fills;
      int flushes;
      int lookups_hit;
      int straddles;
      int second_halves;

      function new();
         tag[0] = '1;
         tag[1] = '1;
         line[0] = '0;
         line[1] = '0;
         line_flt[0] = 1'b0;
         line_flt[1] = 1'b0;
         pend_addr = '0;
         cur_addr = '0;
         second_half = 1'b0;
         held_valid = 1'b0;
         held_word = '0;
         held_fault = 1'b0;
         hs_state = HS_IDLE;
      endfunction

      function logic [WORD_WIDTH-1:0] word_at(logic [1:0] sel, logic [LINE_WIDTH-1:0] d0,
                                              logic [LINE_WIDTH-1:0] d1);
         logic [2*LINE_WIDTH-1:0] pair;
         pair = {d1, d0} >> {sel, 4'b0};
         return pair[WORD_WIDTH-1:0];
      endfunction

      function logic fault_at(logic [1:0] sel, logic f0, logic f1);
         return (sel == SEL_STRADDLE) ? (f0 | f1) : f0;
      endfunction

      function mflb_hit_type find_line(logic [AW-1:0] addr, logic line_en, logic rsp_en,
                                       logic [LINE_WIDTH-1:0] rdata, logic rfault);
         mflb_hit_type h;
         h = '0;
         if (addr[AW-1:3] == tag[0]) begin
            h.data = line[0];
            h.fault = line_flt[0];
            h.src = line_en ? SRC_L1 : SRC_NONE;
         end else if (addr[AW-1:3] == tag[1]) begin
            h.data = line[1];
            h.fault = line_flt[1];
            h.src = line_en ? SRC_L2 : SRC_NONE;
         end else if (addr[AW-1:3] == pend_addr[AW-1:3]) begin
            h.data = rdata;
            h.fault = rfault;
            h.src = rsp_en ? SRC_RSP : SRC_NONE;
         end
         return h;
      endfunction

      function hs_state_type after_accept(logic need, logic mrdy);
         if (!need) return HS_ACCEPT;
         return mrdy ? HS_RESP : HS_GRANT;
      endfunction

      function port_outputs_type note_fetch_cycle(fetch_cycle_type c);
         port_outputs_type o;
         mflb_hit_type hit0, hit1, hold0, hold1;
         logic dbl, waitr, rcv, need, rready, fire, memv, reuse, nhv, nhf, ndbl;
         logic [AW-1:0] a0, a1, h0, h1, maddr, ncur, npend;
         logic [WORD_WIDTH-1:0] nhw;
         logic [TW-1:0] ptag;
         hs_state_type st, nst;
         dbl = second_half;
         st = hs_state;
         waitr = (st == HS_RESP) && !c.mem_resp_valid;
         rcv = !waitr && (c.req_valid || dbl);
         a0 = dbl ? cur_addr : c.req_address;
         a1 = a0 + AW'(2);
         h0 = cur_addr;
         h1 = cur_addr + AW'(2);
         hit0 = find_line(a0, rcv, c.mem_resp_valid, c.mem_resp_data, c.mem_resp_fault);
         hit1 = find_line(a1, rcv, c.mem_resp_valid, c.mem_resp_data, c.mem_resp_fault);
         hold0 = find_line(h0, 1'b1, 1'b0, c.mem_resp_data, c.mem_resp_fault);
         hold1 = find_line(h1, 1'b1, 1'b0, c.mem_resp_data, c.mem_resp_fault);
         need = !(hit0.src != SRC_NONE && hit1.src != SRC_NONE);
         nhv = held_valid;
         nhw = held_word;
         nhf = held_fault;
         nst = st;
         ndbl = dbl;
         ncur = cur_addr;
         npend = pend_addr;

         if (rcv && !need) begin
            nhv = 1'b1;
            nhw = word_at(c.req_address[2:1], hit0.data, hit1.data);
            nhf = fault_at(c.req_address[2:1], hit0.fault, hit1.fault);
            lookups_hit++;
         end else if (c.resp_ready) begin
            nhv = 1'b0;
            nhw = '0;
            nhf = 1'b0;
         end

         memv = need && rcv;
         if (dbl) maddr = {h1[AW-1:3], 3'b000};
         else if (hit0.src == SRC_NONE) maddr = {a0[AW-1:3], 3'b000};
         else maddr = {a1[AW-1:3], 3'b000};

         rready = !need || (c.mem_req_ready && !waitr);
         fire = rcv && rready;
         if ((memv && c.mem_req_ready && !waitr) || (dbl && !waitr)) npend = maddr;

         case (st)
            HS_IDLE: begin
               if (rcv) nst = after_accept(need, c.mem_req_ready);
            end
            HS_GRANT: begin
               if (c.mem_req_ready) nst = HS_RESP;
               else if (!need) nst = HS_ACCEPT;
            end
            HS_RESP: begin
               if (c.mem_resp_valid) begin
                  if (!c.resp_ready) nst = HS_ACCEPT;
                  else if (!rcv) nst = HS_IDLE;
                  else nst = after_accept(need, c.mem_req_ready);
               end
            end
            default: begin
               if (c.resp_ready) nst = rcv ? after_accept(need, c.mem_req_ready) : HS_IDLE;
            end
         endcase

         if (fire) begin
            ndbl = (c.req_address[2:1] == SEL_STRADDLE) && hit0.src == SRC_NONE
                   && hit1.src == SRC_NONE && !dbl;
            if (!dbl) ncur = c.req_address;
            if (c.req_address[2:1] == SEL_STRADDLE) straddles++;
            if (ndbl) second_halves++;
         end

         o.req_ready = rready;
         o.mem_req_valid = memv;
         o.mem_req_address = maddr;
         o.resp_valid = (st == HS_ACCEPT) ? !dbl : (c.mem_resp_valid && !dbl);
         o.resp_address = cur_addr;
         o.resp_data = held_valid ? held_word : word_at(h0[2:1], hold0.data, hold1.data);
         o.resp_fault = held_valid ? held_fault : fault_at(h0[2:1], hold0.fault, hold1.fault);
         o.control_state = st;

         if (c.mem_resp_valid) begin
            reuse = 1'b0;
            ptag = pend_addr[AW-1:3];
            if (c.resp_ready) begin
               if (((hit0.src | hit1.src) & SRC_L2) != SRC_NONE && tag[1] != maddr[AW-1:3])
                  reuse = need;
            end else begin
               if (((hold0.src | hold1.src) & SRC_L2) != SRC_NONE
                   && ((hold0.src | hold1.src) & SRC_L1) == SRC_NONE && tag[1] != ptag)
                  reuse = 1'b1;
            end
            if (!reuse) begin
               tag[1] = tag[0];
               line[1] = line[0];
               line_flt[1] = line_flt[0];
            end
            tag[0] = ptag;
            line[0] = c.mem_resp_data;
            line_flt[0] = c.mem_resp_fault;
            fills++;
         end
         if (c.flush) begin
            tag[0] = '1;
            tag[1] = '1;
            flushes++;
         end

         pend_addr = npend;
         cur_addr = ncur;
         second_half = ndbl;
         held_valid = nhv;
         held_word = nhw;
         held_fault = nhf;
         hs_state = nst;
         requests++;
         expected_outputs.push_back(o);
         return o;
      endfunction

      function void compare_field(string name, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            $error("%s: expected %h, got %h", name, want, got);
            errors++;
         end
      endfunction

      function void check_outputs(port_outputs_type got);
         port_outputs_type want;
         if (expected_outputs.size() == 0) begin
            $error("result arrived with no request outstanding");
            errors++;
            return;
         end
         want = expected_outputs.pop_front();
         checked++;
         compare_field("req_ready", 64'(want.req_ready), 64'(got.req_ready));
         compare_field("mem_req_valid", 64'(want.mem_req_valid), 64'(got.mem_req_valid));
         compare_field("mem_req_address", 64'(want.mem_req_address),
                       64'(got.mem_req_address));
         compare_field("resp_valid", 64'(want.resp_valid), 64'(got.resp_valid));
         compare_field("resp_address", 64'(want.resp_address), 64'(got.resp_address));
         compare_field("resp_data", 64'(want.resp_data), 64'(got.resp_data));
         compare_field("resp_fault", 64'(want.resp_fault), 64'(got.resp_fault));
         compare_field("control_state", 64'(want.control_state), 64'(got.control_state));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_req_valid = 1'b0;
   logic [AW-1:0] req_req_address = '0;
   logic req_mem_req_ready = 1'b0;
   logic req_mem_resp_valid = 1'b0;
   logic [LINE_WIDTH-1:0] req_mem_resp_data = '0;
   logic req_mem_resp_fault = 1'b0;
   logic req_resp_ready = 1'b0;
   logic req_flush = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_req_ready;
   logic rsp_mem_req_valid;
   logic [AW-1:0] rsp_mem_req_address;
   logic rsp_resp_valid;
   logic [AW-1:0] rsp_resp_address;
   logic [WORD_WIDTH-1:0] rsp_resp_data;
   logic rsp_resp_fault;
   logic [STATE_WIDTH-1:0] rsp_control_state;

   int idle_pct = 29;
   int stall_pct = 57;
   logic fetch_busy = 1'b0;
   logic [AW-1:0] fetch_pc = '0;
   logic [AW-1:0] region_base = AW'(32'h0000_1000);

   line_buffer_scoreboard sb = new();

   misaligned_fetch_line_buffer dut (.*);

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            sb.check_outputs({rsp_req_ready, rsp_mem_req_valid, rsp_mem_req_address,
                              rsp_resp_valid, rsp_resp_address, rsp_resp_data,
                              rsp_resp_fault, rsp_control_state});
         end
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("Timed out after %0d cycles without a transfer.", STALL_LIMIT);
      $display("TEST FAILED");
      $finish;
   end

   function automatic fetch_cycle_type fetch_cycle(int v, logic [AW-1:0] addr, int mrdy,
                                                   int rspv, logic [LINE_WIDTH-1:0] data,
                                                   int fault, int crdy, int fl);
      fetch_cycle_type c;
      c.req_valid = v[0];
      c.req_address = addr;
      c.mem_req_ready = mrdy[0];
      c.mem_resp_valid = rspv[0];
      c.mem_resp_data = data;
      c.mem_resp_fault = fault[0];
      c.resp_ready = crdy[0];
      c.flush = fl[0];
      return c;
   endfunction

   // Mostly a fetch unit that holds its address until taken and a memory that
   // answers while the controller waits for a line; the rest is noise.
   function automatic fetch_cycle_type make_fetch_cycle();
      fetch_cycle_type c;
      int pick;
      c.mem_resp_data = {$urandom, $urandom};
      if ($urandom_range(0, 9) == 0) begin
         c.req_valid = 1'($urandom_range(0, 1));
         c.req_address = AW'($urandom);
         c.mem_req_ready = 1'($urandom_range(0, 1));
         c.mem_resp_valid = 1'($urandom_range(0, 1));
         c.mem_resp_fault = 1'($urandom_range(0, 1));
         c.resp_ready = 1'($urandom_range(0, 1));
         c.flush = ($urandom_range(0, 7) == 0);
         return c;
      end
      if (!fetch_busy && $urandom_range(0, 99) < 80) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            fetch_pc = fetch_pc + ($urandom_range(0, 1) ? AW'(4) : AW'(2));
         end else if (pick < 85) begin
            fetch_pc = region_base + AW'(2 * $urandom_range(0, 15));
         end else if (pick < 95) begin
            region_base = AW'($urandom);
            fetch_pc = region_base;
         end else begin
            fetch_pc = AW'(32'hFFFF_FFF0) + AW'(2 * $urandom_range(0, 7));
         end
         fetch_pc[0] = ($urandom_range(0, 99) < 4);
         fetch_busy = 1'b1;
      end
      c.req_valid = fetch_busy;
      c.req_address = fetch_pc;
      c.mem_req_ready = ($urandom_range(0, 99) < 70);
      if (sb.hs_state == HS_RESP) c.mem_resp_valid = ($urandom_range(0, 99) < 60);
      else c.mem_resp_valid = ($urandom_range(0, 99) < 4);
      c.mem_resp_fault = ($urandom_range(0, 99) < 6);
      c.resp_ready = ($urandom_range(0, 99) < 75);
      c.flush = ($urandom_range(0, 99) < 2);
      return c;
   endfunction

   task automatic run_fetch_cycle(input fetch_cycle_type c);
      port_outputs_type o;
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_req_valid <= c.req_valid;
      req_req_address <= c.req_address;
      req_mem_req_ready <= c.mem_req_ready;
      req_mem_resp_valid <= c.mem_resp_valid;
      req_mem_resp_data <= c.mem_resp_data;
      req_mem_resp_fault <= c.mem_resp_fault;
      req_resp_ready <= c.resp_ready;
      req_flush <= c.flush;
      do @(posedge clock); while (req_stall !== 1'b0);
      o = sb.note_fetch_cycle(c);
      if (c.req_valid && o.req_ready) fetch_busy = 1'b0;
   endtask

   initial begin : stimulus
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      run_fetch_cycle(fetch_cycle(0, '0, 0, 0, '0, 0, 0, 0));
      run_fetch_cycle(fetch_cycle(1, AW'(32'h6), 1, 0, '0, 0, 1, 0));
      run_fetch_cycle(fetch_cycle(1, AW'(32'h6), 1, 1, 64'h1122_3344_5566_7788, 0, 1, 0));
      run_fetch_cycle(fetch_cycle(0, '0, 1, 1, '1, 1, 0, 0));
      run_fetch_cycle(fetch_cycle(1, AW'(32'h4), 1, 0, '0, 0, 1, 0));
      run_fetch_cycle(fetch_cycle(1, AW'(32'h2), 1, 0, '0, 0, 1, 0));
      run_fetch_cycle(fetch_cycle(1, '1 - AW'(1), 0, 0, '0, 0, 1, 0));
      run_fetch_cycle(fetch_cycle(1, '1 - AW'(1), 1, 0, '0, 0, 1, 0));
      run_fetch_cycle(fetch_cycle(0, '0, 1, 1, '0, 0, 1, 0));
      run_fetch_cycle(fetch_cycle(0, '0, 1, 1, '1, 0, 1, 0));
      run_fetch_cycle(fetch_cycle(1, '1, 1, 0, '0, 0, 1, 0));
      run_fetch_cycle(fetch_cycle(0, '0, 1, 1, 64'h0F0F_0F0F_F0F0_F0F0, 1, 1, 1));
      run_fetch_cycle(fetch_cycle(1, AW'(32'h3), 1, 0, '0, 0, 1, 0));
      run_fetch_cycle(fetch_cycle(0, '0, 1, 1, 64'hA5A5_A5A5_A5A5_A5A5, 0, 0, 0));
      run_fetch_cycle(fetch_cycle(0, '0, 0, 0, '0, 0, 0, 0));
      run_fetch_cycle(fetch_cycle(1, AW'(32'h2), 0, 0, '0, 0, 1, 0));
      run_fetch_cycle(fetch_cycle(1, AW'(32'h8000_0000), 1, 0, '0, 0, 1, 1));
      run_fetch_cycle(fetch_cycle(0, '0, 1, 1, 64'h5A5A_5A5A_5A5A_5A5A, 1, 1, 0));
      run_fetch_cycle(fetch_cycle(1, AW'(32'h8000_0006), 1, 1, '1, 0, 1, 0));
      run_fetch_cycle(fetch_cycle(0, '0, 1, 1, '0, 1, 1, 0));
      run_fetch_cycle(fetch_cycle(0, '0, 0, 0, '0, 0, 1, 0));

      for (int phase = 0; phase < 3; phase++) begin
         idle_pct = (phase == 0) ? 29 : (phase == 1) ? 57 : 0;
         stall_pct = (phase == 0) ? 57 : (phase == 1) ? 29 : 0;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) run_fetch_cycle(make_fetch_cycle());
      end
      req_valid <= 1'b0;

      while (sb.expected_outputs.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      $display("Ran %0d fetch cycles, checked %0d; %0d line fills, %0d flushes.",
               sb.requests, sb.checked, sb.fills, sb.flushes);
      $display("Saw %0d buffer hits, %0d straddling fetches, %0d double line requests.",
               sb.lookups_hit, sb.straddles, sb.second_halves);
      if (sb.errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
src/mflb_pkg.sv
src/mflb_lookup.sv
src/mflb_core.sv
src/misaligned_fetch_line_buffer.sv
sim/tb.sv
